// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("session slot allocator check failed");

// Check that a condition never holds outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("session slot allocator forbidden condition");

`endif

// ----- hdl/ssa_pkg.sv -----
// Shared types, constants and helpers of the session slot allocator
`default_nettype none

package ssa_pkg;

    localparam int MAX_SLOTS = 64;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int CNT_W     = 7;
    localparam int ID_W      = 16;
    localparam int HND_W     = 32;
    localparam int START_ID  = 1;
    localparam int GEN_BIT   = 15;
    localparam int PADDR_W   = 3;

    localparam logic [CNT_W-1:0] SLOTS_RESET = CNT_W'(64);

    typedef enum logic [2:0] {
        ACT_ACCEPT  = 3'd0,
        ACT_RELEASE = 3'd1,
        ACT_SEARCH  = 3'd2,
        ACT_FIRST   = 3'd3,
        ACT_NEXT    = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_MISS  = 2'd1,
        STS_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } ssa_state_t;

    typedef struct packed {
        logic capture;
        logic execute;
        logic load;
    } ssa_cmd_t;

    typedef struct packed {
        logic out_valid;
    } ssa_stat_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
    } find_t;

    function automatic find_t find_lowest(input logic [MAX_SLOTS-1:0] vec);
        find_t res;
        res.found = 1'b0;
        res.slot  = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
            if (vec[i]) begin
                res.found = 1'b1;
                res.slot  = SLOT_W'(i);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/ssa_regs.sv -----
// Configuration register port of the session slot allocator
`default_nettype none

module ssa_regs
    import ssa_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    output logic      [CNT_W-1:0]   cfg_slots
);

    logic [CNT_W-1:0] slots_reg;
    logic [CNT_W-1:0] slots_next;
    logic             sel_slots;

    assign pready    = 1'b1;
    assign sel_slots = (paddr[PADDR_W-1:2] == '0);

    always_comb
    begin
        slots_next = slots_reg;
        if (psel && penable && pwrite && pready && sel_slots)
        begin
            slots_next = pwdata[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= SLOTS_RESET;
        end
        else
        begin
            slots_reg <= slots_next;
        end
    end

    assign prdata    = sel_slots ? {{(32-CNT_W){1'b0}}, slots_reg} : 32'd0;
    assign cfg_slots = slots_reg;

endmodule

`default_nettype wire

// ----- hdl/ssa_ctrl.sv -----
// Controller state machine of the session slot allocator
`default_nettype none

module ssa_ctrl
    import ssa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      out_ready,
    input  wire ssa_stat_t stat,
    output logic           in_ready,
    output ssa_cmd_t       cmd
);

    ssa_state_t state_reg;
    ssa_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next  = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (!stat.out_valid || out_ready)
                begin
                    cmd.load = 1'b1;
                    in_ready = 1'b1;
                    if (in_valid)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = ST_EXEC;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/ssa_datapath.sv -----
// Slot flags, handle memory and result path of the session slot allocator
`default_nettype none

module ssa_datapath
    import ssa_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ssa_cmd_t         cmd,
    input  wire logic [CNT_W-1:0] cfg_slots,
    input  wire logic [2:0]       in_action,
    input  wire logic [ID_W-1:0]  in_sess_id,
    input  wire logic [HND_W-1:0] in_handle,
    input  wire logic             out_ready,
    output ssa_stat_t             stat,
    output logic                  out_valid,
    output logic      [1:0]       out_status,
    output logic      [ID_W-1:0]  out_result_id,
    output logic      [HND_W-1:0] out_result_handle,
    output logic      [CNT_W-1:0] out_active_count
);

    localparam logic [ID_W-1:0] GEN_MASK = ID_W'(1) << GEN_BIT;
    localparam logic [ID_W-1:0] START    = ID_W'(START_ID);

    logic [2:0]           action_reg;
    logic [ID_W-1:0]      sid_reg;
    logic [HND_W-1:0]     hnd_reg;

    logic [MAX_SLOTS-1:0] used_reg,  used_next;
    logic [MAX_SLOTS-1:0] gen_reg,   gen_next;
    logic [MAX_SLOTS-1:0] nz_reg,    nz_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    logic [1:0]           status_reg, status_next;
    logic [ID_W-1:0]      rid_reg,    rid_next;
    logic                 hsel_reg,   hsel_next;

    logic                 ovalid_reg, ovalid_next;
    logic [1:0]           ostatus_reg;
    logic [ID_W-1:0]      orid_reg;
    logic [HND_W-1:0]     ohnd_reg;
    logic [CNT_W-1:0]     ocount_reg;

    logic [HND_W-1:0]     handle_mem [MAX_SLOTS];
    logic [HND_W-1:0]     mem_q;
    logic                 mem_we;
    logic                 mem_re;
    logic [SLOT_W-1:0]    mem_addr;

    logic [CNT_W-1:0]     limit;
    logic [MAX_SLOTS-1:0] in_limit;
    logic [MAX_SLOTS-1:0] from_mask;
    logic [ID_W-1:0]      bare;
    logic [ID_W-1:0]      idx;
    logic                 id_ok;
    logic [SLOT_W-1:0]    slot;
    logic [CNT_W-1:0]     scan_from;
    find_t                free_hit;
    find_t                scan_hit;

    always_comb
    begin
        limit = (cfg_slots > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : cfg_slots;
        bare  = sid_reg & ~GEN_MASK;
        idx   = bare - START;
        id_ok = (bare >= START) && (idx < ID_W'(limit));
        slot  = idx[SLOT_W-1:0];
        scan_from = (action_reg == ACT_NEXT) ? (CNT_W'(slot) + CNT_W'(1)) : '0;
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            in_limit[i]  = (CNT_W'(i) < limit);
            from_mask[i] = (CNT_W'(i) >= scan_from);
        end
        free_hit = find_lowest(~used_reg & in_limit);
        scan_hit = find_lowest(used_reg & nz_reg & in_limit & from_mask);
    end

    always_comb
    begin
        used_next   = used_reg;
        gen_next    = gen_reg;
        nz_next     = nz_reg;
        count_next  = count_reg;
        status_next = status_reg;
        rid_next    = rid_reg;
        hsel_next   = hsel_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = slot;
        if (cmd.execute)
        begin
            status_next = STS_RANGE;
            rid_next    = '0;
            hsel_next   = 1'b0;
            unique case (action_reg)
                ACT_ACCEPT:
                begin
                    status_next = STS_MISS;
                    mem_addr    = free_hit.slot;
                    if (free_hit.found)
                    begin
                        used_next[free_hit.slot] = 1'b1;
                        nz_next[free_hit.slot]   = (hnd_reg != '0);
                        mem_we      = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                        status_next = STS_OK;
                        rid_next    = ID_W'(free_hit.slot) + START;
                        if (gen_reg[free_hit.slot])
                        begin
                            rid_next = rid_next | GEN_MASK;
                        end
                    end
                end
                ACT_RELEASE:
                begin
                    if (id_ok && used_reg[slot])
                    begin
                        used_next[slot] = 1'b0;
                        nz_next[slot]   = 1'b0;
                        gen_next[slot]  = ~gen_reg[slot];
                        count_next      = count_reg - CNT_W'(1);
                        status_next     = STS_OK;
                    end
                end
                ACT_SEARCH:
                begin
                    if (id_ok && used_reg[slot])
                    begin
                        status_next = STS_OK;
                        rid_next    = sid_reg;
                        hsel_next   = 1'b1;
                        mem_re      = 1'b1;
                    end
                end
                ACT_FIRST, ACT_NEXT:
                begin
                    mem_addr = scan_hit.slot;
                    if (action_reg == ACT_FIRST || id_ok)
                    begin
                        if (scan_hit.found)
                        begin
                            status_next = STS_OK;
                            rid_next    = ID_W'(scan_hit.slot) + START;
                            hsel_next   = 1'b1;
                            mem_re      = 1'b1;
                        end
                        else
                        begin
                            status_next = STS_MISS;
                        end
                    end
                end
                default:
                begin
                    status_next = STS_RANGE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            handle_mem[mem_addr] <= hnd_reg;
        end
        if (mem_re)
        begin
            mem_q <= handle_mem[mem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= in_action;
            sid_reg    <= in_sess_id;
            hnd_reg    <= in_handle;
        end
        status_reg <= status_next;
        rid_reg    <= rid_next;
        hsel_reg   <= hsel_next;
        if (cmd.load)
        begin
            ostatus_reg <= status_reg;
            orid_reg    <= rid_reg;
            ohnd_reg    <= hsel_reg ? mem_q : '0;
            ocount_reg  <= count_reg;
        end
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (cmd.load)
        begin
            ovalid_next = 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg   <= '0;
            gen_reg    <= '0;
            nz_reg     <= '0;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            used_reg   <= used_next;
            gen_reg    <= gen_next;
            nz_reg     <= nz_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign stat.out_valid    = ovalid_reg;
    assign out_valid         = ovalid_reg;
    assign out_status        = ostatus_reg;
    assign out_result_id     = orid_reg;
    assign out_result_handle = ohnd_reg;
    assign out_active_count  = ocount_reg;

endmodule

`default_nettype wire

// ----- hdl/session_slot_allocator.sv -----
// Session slot allocator: first-fit slot table with generation bits
// An input transfer is captured, then executed (flag search and handle
// memory access) and then loaded into the output registers; a new input is
// accepted in the load step, which waits while a result is held unaccepted.
// Reset clears all used, generation and handle flags, the active count and
// sets the slot count register to 64; the handle memory needs no clearing pass.
`default_nettype none

module session_slot_allocator
    import ssa_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [47:0]        s_axis_tdata,  // sess_id[15:0], handle[47:16]
    input  wire logic [2:0]         s_axis_tuser,  // action[2:0]
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic      [55:0]        m_axis_tdata,  // result_id[15:0], result_handle[47:16],
                                                   // active_count[54:48], zero[55]
    output logic      [1:0]         m_axis_tuser,  // status[1:0]
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    ssa_cmd_t         cmd;
    ssa_stat_t        stat;
    logic [CNT_W-1:0] cfg_slots;
    logic [ID_W-1:0]  result_id;
    logic [HND_W-1:0] result_handle;
    logic [CNT_W-1:0] active_count;

    ssa_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cfg_slots (cfg_slots)
    );

    ssa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .in_ready  (s_axis_tready),
        .cmd       (cmd)
    );

    ssa_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .cfg_slots         (cfg_slots),
        .in_action         (s_axis_tuser),
        .in_sess_id        (s_axis_tdata[15:0]),
        .in_handle         (s_axis_tdata[47:16]),
        .out_ready         (m_axis_tready),
        .stat              (stat),
        .out_valid         (m_axis_tvalid),
        .out_status        (m_axis_tuser),
        .out_result_id     (result_id),
        .out_result_handle (result_handle),
        .out_active_count  (active_count)
    );

    assign m_axis_tdata = {1'b0, active_count, result_handle, result_id};

endmodule

`default_nettype wire

// ----- hdl/ssa_checker.sv -----
// Port-level checker of the session slot allocator and its bind
`default_nettype none

`include "assert_macros.svh"

module ssa_checker
    import ssa_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [55:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    `ASSERT_NEVER(a_status_code, clk, rst_n, m_axis_tvalid && (m_axis_tuser == 2'd3))
    `ASSERT_NEVER(a_count_max, clk, rst_n, m_axis_tvalid && (m_axis_tdata[54:48] > 7'd64))
    `ASSERT_CLK(a_miss_empty, clk, rst_n, (m_axis_tvalid && (m_axis_tuser == STS_MISS)) |-> (m_axis_tdata[47:0] == 48'd0))
    `ASSERT_CLK(a_hold, clk, rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))

endmodule

bind session_slot_allocator ssa_checker u_ssa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
